>>> rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tdpt_pkg.sv
// types and constants shared by the prime test controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;
    localparam int SMALLEST_PRIME = 2;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_d;
        logic push;
        logic out_bit;
    } cmd_t;

    typedef struct packed {
        logic trivial;
        logic trivial_prime;
        logic div_last;
        logic d_gt_q;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/tdpt_dp.sv
// datapath: operand and divisor registers, restoring divider, output register
// depends on tdpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdpt_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire tdpt_pkg::cmd_t                cmd,
    output tdpt_pkg::sts_t                     sts,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               is_prime
);
    import tdpt_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] CNT_TOP    = CW'(VALUE_WIDTH - 1);
    localparam logic [W-1:0]  D_FIRST    = W'(FIRST_DIVISOR);
    localparam logic [W-1:0]  D_STEP     = W'(DIVISOR_STEP);
    localparam logic [W-1:0]  PRIME_LOW  = W'(SMALLEST_PRIME);

    logic [W-1:0]  n_reg,   n_next;
    logic [W-1:0]  d_reg,   d_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          is_prime_reg,  is_prime_next;

    logic [W:0]    trial;
    logic          fits;

    // one restoring step
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, d_reg};
    assign fits  = ~trial[W];

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next = value;
            d_next = D_FIRST;
        end
        if (cmd.next_d)
        begin
            d_next = d_reg + D_STEP;
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            quo_next = n_reg;
            cnt_next = CNT_TOP;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                rem_next = trial[W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
            end
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            is_prime_next  = cmd.out_bit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_prime_reg <= is_prime_next;
    end

    // negative, below two or even values need no division
    always_comb
    begin
        sts.trivial       = n_reg[W-1] | (n_reg < PRIME_LOW) | ~n_reg[0];
        sts.trivial_prime = (n_reg == PRIME_LOW);
        sts.div_last      = (cnt_reg == '0);
        sts.d_gt_q        = (d_reg > quo_reg);
        sts.rem_zero      = (rem_reg == '0);
        sts.out_free      = ~out_valid_reg | ~out_stall;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

`default_nettype wire

>>> rtl/tdpt_ctrl.sv
// controller: sequences classification, trial divisions and result transfer
// depends on tdpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdpt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tdpt_pkg::sts_t sts,
    output tdpt_pkg::cmd_t      cmd
);
    import tdpt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg,  state_next;
    logic       result_reg, result_next;

    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        cmd         = '0;
        cmd.out_bit = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (sts.trivial)
                begin
                    result_next = sts.trivial_prime;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.d_gt_q)
                begin
                    result_next = 1'b1;
                    state_next  = ST_FIN;
                end
                else if (sts.rem_zero)
                begin
                    result_next = 1'b0;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.next_d    = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            result_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/trial_division_prime_test.sv
// top level of the trial division prime test
// depends on tdpt_pkg, tdpt_ctrl, tdpt_dp and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Tests one signed value per transfer and returns one is_prime bit per value.
// Negative values, 0, 1 and every even value resolve without any division.
// An odd value n is divided by 3, 5, 7, ... while d*d <= n, each division on
// one shared restoring divider that produces one quotient bit per cycle. Worst
// case (a prime near 2^31 at the default width) is about 23200 divisors.
// One value is in work at a time; the result sits in an output register, so
// a stalled result does not block the next value until its own result is ready.

`include "assert_macros.svh"

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               is_prime
);
    import tdpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tdpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdpt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "busy flag missing after input transfer")
    `ASSERT_SAME(a_push_when_free, clk, rst_n, cmd.push, sts.out_free, "result pushed over a pending result")
    `ASSERT_SAME(a_valid_from_push, clk, rst_n, $rose(out_valid), $past(cmd.push), "output valid without a pushed result")

endmodule

`default_nettype wire

>>> dv/prime_flag_checker.sv
// checker for the trial division prime test: predicts is_prime for every accepted value
// and compares each result transfer against the oldest outstanding prediction
// no dependencies
`timescale 1ns / 1ps

module prime_flag_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          is_prime,
    output int                                 fails,
    output int                                 pending,
    output int                                 checked,
    output int                                 primes
);

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   flag;
    } verdict_t;

    verdict_t verdict_q[$];
    int       accepted;

    function automatic logic prime_flag(input logic [VALUE_WIDTH-1:0] n);
        longint unsigned num;
        longint unsigned d;
        num = 64'(n);
        if (n[VALUE_WIDTH-1])
            return 1'b0;
        if (num < 2)
            return 1'b0;
        if (num == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        for (d = 3; d <= num / d; d += 2)
        begin
            if (num % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    assign pending = accepted - checked;

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t head;
        verdict_t fresh;
        if (!rst_n)
        begin
            verdict_q.delete();
            fails    <= 0;
            accepted <= 0;
            checked  <= 0;
            primes   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing outstanding, got is_prime %0b",
                             $time, is_prime);
                    fails <= fails + 1;
                end
                else
                begin
                    head = verdict_q.pop_front();
                    if (is_prime !== head.flag)
                    begin
                        $display("%0t: is_prime for value %0d: expected %0b, actual %0b",
                                 $time, $signed(head.value), head.flag, is_prime);
                        fails <= fails + 1;
                    end
                    checked <= checked + 1;
                    if (head.flag)
                        primes <= primes + 1;
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh.value = value;
                fresh.flag  = prime_flag(value);
                verdict_q.push_back(fresh);
                accepted <= accepted + 1;
            end
        end
    end

endmodule

>>> dv/trial_division_prime_test_tb.sv
// testbench top for trial_division_prime_test: drives values, stalls results, gives the verdict
// depends on trial_division_prime_test and prime_flag_checker
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

    localparam int     VALUE_WIDTH = 32;
    localparam int     HOLD_CYCLES = 400;
    localparam int     PHASE_ITEMS = 17;
    localparam int     CORNER_COUNT = 24;
    localparam longint CYCLE_LIMIT = 10_000_000;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic signed [VALUE_WIDTH-1:0] value     = '0;
    logic                          out_stall = 1'b0;
    wire logic                     in_stall;
    wire logic                     out_valid;
    wire logic                     is_prime;

    int     send_gap_pct     = 0;
    int     result_stall_pct = 0;
    logic   hold_req         = 1'b0;
    logic   hold_ack;
    int     hold_left;
    longint cycles           = 0;

    int fails;
    int pending;
    int checked;
    int primes;

    logic signed [VALUE_WIDTH-1:0] corner_values [CORNER_COUNT] = '{
        32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4,
        32'd5, 32'd9, 32'd15, 32'd25, 32'd49, 32'd97, 32'd121, 32'd169,
        32'd65521, 32'd65535, 32'd1000003, 32'd16752649, 32'h4000_0000,
        32'd2147483645, 32'd2147483646, 32'd2147483647
    };

    always #10 clk = ~clk;

    trial_division_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    prime_flag_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .fails     (fails),
        .pending   (pending),
        .checked   (checked),
        .primes    (primes)
    );

    // result side: random stalls, or a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_ack  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_ack  <= hold_req;
        end
        else
            out_stall <= ($urandom_range(99) < result_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return $urandom() | 32'h8000_0000;
        if (pick < 30)
            return $urandom() & 32'h7FFF_FFFE;
        if (pick < 40)
            return $urandom_range(16);
        if (pick < 90)
            return $urandom_range(65535, 3) | 1;
        return $urandom_range(262143, 65537) | 1;
    endfunction

    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
            send_value(corner_values[i]);
        drain();

        // hold results back while quick values keep coming, then wait for all of them
        hold_req <= ~hold_req;
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 0)
                send_value($urandom() | 32'h8000_0000);
            else
                send_value($urandom_range(16));
        end
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  result_stall_pct <= 0;  end
                1: begin send_gap_pct = 73; result_stall_pct <= 0;  end
                2: begin send_gap_pct = 0;  result_stall_pct <= 73; end
                default: begin send_gap_pct = 31; result_stall_pct <= 31; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(random_value());
            drain();
        end

        repeat (50) @(posedge clk);

        $display("checked %0d values, %0d of them prime, over corner values, four idle mixes",
                 checked, primes);
        $display("and a %0d-cycle result hold that backed up the input", HOLD_CYCLES);
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
